// ===== design/preemptive_priority_scheduler_core_assert.svh =====
// Assertion macros for the preemptive priority scheduler core.
// Needs clk_i and rst_ni in the scope of the including module.
`ifndef PREEMPTIVE_PRIORITY_SCHEDULER_CORE_ASSERT_SVH
`define PREEMPTIVE_PRIORITY_SCHEDULER_CORE_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define PPSC_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define PPSC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/ppsc_pkg.sv =====
// Shared types and constants of the preemptive priority scheduler.
// No dependencies; imported by every module of the block.
package ppsc_pkg;

  localparam int DEF_MAX_TASKS  = 16;
  localparam int DEF_TICK_WIDTH = 20;

  localparam int SLOT_W  = 4;
  localparam int ARR_W   = 16;
  localparam int BURST_W = 16;
  localparam int PRIO_W  = 8;
  localparam int OUT_W   = 20;
  localparam int CFG_W   = 5;

  localparam logic [CFG_W-1:0] ENTRIES_RST = 5'd16;
  localparam logic [CFG_W-1:0] DONE_MAX    = 5'd31;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_TICK = 1'b1;

  typedef struct packed {
    logic [ARR_W-1:0]   arrival;
    logic [BURST_W-1:0] burst;
    logic [BURST_W-1:0] remaining;
    logic [PRIO_W-1:0]  prio;
  } task_entry_t;

  typedef struct packed {
    logic clear;     // start of a new tick: forget the previous winner
    logic cand_vld;  // memory read data holds a candidate this cycle
  } pick_ctrl_t;

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_SCAN   = 4'b0010,
    ST_CALC   = 4'b0100,
    ST_UPDATE = 4'b1000
  } sched_state_e;

endpackage

// ===== design/ppsc_task_mem.sv =====
// Task table: single-port synchronous memory with a registered read.
// Depends on ppsc_pkg for the entry type.
module ppsc_task_mem import ppsc_pkg::*; #(
  parameter int DEPTH = DEF_MAX_TASKS,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] addr_i,
  input  task_entry_t   wdata_i,
  output task_entry_t   rdata_o
);

  task_entry_t mem_q [DEPTH];
  task_entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== design/ppsc_pick.sv =====
// Running winner selection over the entries streamed out of the task table.
// Depends on ppsc_pkg for the entry and control types.
module ppsc_pick import ppsc_pkg::*; #(
  parameter int MAX_TASKS = DEF_MAX_TASKS,
  parameter int TICK_W    = DEF_TICK_WIDTH
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  pick_ctrl_t                     ctrl_i,
  input  logic [$clog2(MAX_TASKS)-1:0]   cand_slot_i,
  input  task_entry_t                    cand_i,
  input  logic [TICK_W-1:0]              tick_i,
  output logic                           found_o,
  output logic [$clog2(MAX_TASKS)-1:0]   best_slot_o,
  output task_entry_t                    best_o
);

  localparam int IW = $clog2(MAX_TASKS);
  localparam int CW = (TICK_W > ARR_W) ? TICK_W : ARR_W;

  logic          found_q;
  logic [IW-1:0] best_slot_q;
  task_entry_t   best_q;
  logic          eligible;
  logic          better;
  logic          take;

  // Arrived and still has work.
  assign eligible = (CW'(cand_i.arrival) <= CW'(tick_i)) && (cand_i.remaining != '0);

  // Strictly better only: equal priority and arrival keeps the lower slot.
  assign better = !found_q ||
                  (cand_i.prio < best_q.prio) ||
                  ((cand_i.prio == best_q.prio) && (cand_i.arrival < best_q.arrival));

  assign take = ctrl_i.cand_vld && !ctrl_i.clear && eligible && better;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      found_q <= 1'b0;
    end else if (ctrl_i.clear) begin
      found_q <= 1'b0;
    end else if (take) begin
      found_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      best_q      <= cand_i;
      best_slot_q <= cand_slot_i;
    end
  end

  assign found_o     = found_q;
  assign best_slot_o = best_slot_q;
  assign best_o      = best_q;

endmodule

// ===== design/preemptive_priority_scheduler_core.sv =====
// Preemptive priority scheduler core: FSM, time keeping and result beats.
// Depends on ppsc_pkg, ppsc_task_mem, ppsc_pick and the assertion header.
//
// A load (op 0) writes one task slot in the cycle it is accepted; a tick
// (op 1) streams the slots in use out of the task table one per cycle,
// keeps the most urgent ready one (smallest priority number, then earlier
// arrival, then lower slot), decrements its remaining work, writes it back
// and advances time. busy stays high on a tick through the scan, the
// turnaround subtract and the write back, and is never raised by a load.
// The single read port of the task table delivers one entry per cycle,
// the read is registered, and the subtract and write back follow the scan.
// Every accepted item gives exactly one result beat, on the cycle after
// the load or after the write back, marked by result_valid_o for one
// cycle; the receiver cannot stall, so sample it when it shows. The table
// is not cleared at reset: only slots that were loaded may take part.
// entries_in_use is written through cfg_we_i/cfg_wdata_i; the user must
// write it only while idle, as the block itself does not enforce this.
`include "preemptive_priority_scheduler_core_assert.svh"

module preemptive_priority_scheduler_core import ppsc_pkg::*; #(
  parameter int MAX_TASKS  = DEF_MAX_TASKS,
  parameter int TICK_WIDTH = DEF_TICK_WIDTH
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  logic                op_i,
  input  logic [SLOT_W-1:0]   slot_i,
  input  logic [ARR_W-1:0]    arrival_i,
  input  logic [BURST_W-1:0]  burst_i,
  input  logic [PRIO_W-1:0]   prio_level_i,
  input  logic                cfg_we_i,
  input  logic [CFG_W-1:0]    cfg_wdata_i,
  output logic                result_valid_o,
  output logic                ran_valid_o,
  output logic [SLOT_W-1:0]   ran_slot_o,
  output logic                finished_o,
  output logic [OUT_W-1:0]    finish_tick_o,
  output logic [OUT_W-1:0]    turnaround_o,
  output logic [OUT_W-1:0]    wait_ticks_o,
  output logic                all_done_o
);

  localparam int IW  = $clog2(MAX_TASKS);
  localparam int CNW = $clog2(MAX_TASKS + 1);
  localparam int NW  = (CNW > CFG_W) ? CNW : CFG_W;
  localparam int W   = (TICK_WIDTH > OUT_W) ? TICK_WIDTH : OUT_W;
  localparam int SW  = (IW > SLOT_W) ? IW : SLOT_W;
  localparam logic [TICK_WIDTH-1:0] TICK_MAX = {TICK_WIDTH{1'b1}};

  // Control state
  sched_state_e            state_q, state_d;
  logic [NW-1:0]           ptr_q, ptr_d;
  logic                    rd_vld_q, rd_vld_d;
  logic [TICK_WIDTH-1:0]   tick_q, tick_d;
  logic [TICK_WIDTH-1:0]   tick_inc_q, tick_inc_d;   // saturated tick + 1
  logic [CFG_W-1:0]        done_cnt_q, done_cnt_d;
  logic [CFG_W-1:0]        cfg_q;
  logic                    result_valid_q;

  // Payload registers
  logic [IW-1:0]           rd_slot_q;
  logic [W-1:0]            ta_q, ta_d;
  logic                    ran_valid_q, ran_valid_d;
  logic [SLOT_W-1:0]       ran_slot_q, ran_slot_d;
  logic                    finished_q, finished_d;
  logic [OUT_W-1:0]        finish_tick_q, finish_tick_d;
  logic [OUT_W-1:0]        turnaround_q, turnaround_d;
  logic [OUT_W-1:0]        wait_ticks_q, wait_ticks_d;
  logic                    all_done_q, all_done_d;

  logic                    accept;
  logic                    load_acc;
  logic                    tick_acc;
  logic                    slot_ok;
  logic [SW-1:0]           slot_ext;
  logic [NW-1:0]           n_act;
  logic                    issue;

  logic                    mem_we;
  logic [IW-1:0]           mem_addr;
  task_entry_t             mem_wdata;
  task_entry_t             mem_rdata;

  pick_ctrl_t              pick_ctrl;
  logic                    found;
  logic [IW-1:0]           best_slot;
  task_entry_t             best;
  logic [SW-1:0]           best_slot_ext;

  logic                    fin;
  logic [W-1:0]            ft_w;
  logic [W-1:0]            burst_w;
  logic [W-1:0]            wt_w;
  logic [CFG_W-1:0]        done_next;

  assign busy     = (state_q != ST_IDLE);
  assign accept   = start && !busy;
  assign load_acc = accept && (op_i == OP_LOAD);
  assign tick_acc = accept && (op_i == OP_TICK);

  // Drop loads aimed beyond the table.
  assign slot_ext = SW'(slot_i);
  assign slot_ok  = (32'(slot_i) < MAX_TASKS);

  // Slots in use, clipped to the table depth.
  assign n_act = (32'(cfg_q) > MAX_TASKS) ? NW'(MAX_TASKS) : NW'(cfg_q);

  assign issue = (state_q == ST_SCAN) && (ptr_q < n_act);

  // ---------------------------------------------------------------------
  // Task table port: load writes in idle, scan reads, update writes back.
  // Only one of these is ever live, so no forwarding is needed.
  // ---------------------------------------------------------------------
  always_comb begin
    mem_we    = 1'b0;
    mem_addr  = ptr_q[IW-1:0];
    mem_wdata = best;
    mem_wdata.remaining = best.remaining - BURST_W'(1);
    unique case (state_q) inside
      ST_IDLE: begin
        mem_addr            = slot_ext[IW-1:0];
        mem_we              = load_acc && slot_ok;
        mem_wdata.arrival   = arrival_i;
        mem_wdata.burst     = burst_i;
        mem_wdata.remaining = burst_i;
        mem_wdata.prio      = prio_level_i;
      end
      ST_UPDATE: begin
        mem_addr = best_slot;
        mem_we   = found;
      end
      ST_SCAN, ST_CALC: begin
        mem_addr = ptr_q[IW-1:0];
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  ppsc_task_mem #(
    .DEPTH (MAX_TASKS),
    .AW    (IW)
  ) u_task_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .addr_i  (mem_addr),
    .wdata_i (mem_wdata),
    .rdata_o (mem_rdata)
  );

  assign pick_ctrl.clear    = tick_acc;
  assign pick_ctrl.cand_vld = rd_vld_q;

  ppsc_pick #(
    .MAX_TASKS (MAX_TASKS),
    .TICK_W    (TICK_WIDTH)
  ) u_pick (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (pick_ctrl),
    .cand_slot_i (rd_slot_q),
    .cand_i      (mem_rdata),
    .tick_i      (tick_q),
    .found_o     (found),
    .best_slot_o (best_slot),
    .best_o      (best)
  );

  // ---------------------------------------------------------------------
  // Completion bookkeeping for the winner.
  // ---------------------------------------------------------------------
  assign best_slot_ext = SW'(best_slot);
  assign fin           = found && (best.remaining == BURST_W'(1));
  assign ft_w          = W'(tick_inc_q);
  assign burst_w       = W'(best.burst);
  // Clamp a negative wait to zero.
  assign wt_w          = (ta_q >= burst_w) ? (ta_q - burst_w) : '0;
  assign done_next     = (fin && (done_cnt_q < DONE_MAX)) ? (done_cnt_q + CFG_W'(1))
                                                          : done_cnt_q;

  // ---------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------
  always_comb begin
    state_d       = state_q;
    ptr_d         = ptr_q;
    rd_vld_d      = 1'b0;
    tick_d        = tick_q;
    tick_inc_d    = tick_inc_q;
    done_cnt_d    = done_cnt_q;
    ta_d          = ta_q;
    ran_valid_d   = 1'b0;
    ran_slot_d    = '0;
    finished_d    = 1'b0;
    finish_tick_d = '0;
    turnaround_d  = '0;
    wait_ticks_d  = '0;
    all_done_d    = (NW'(done_cnt_q) >= n_act);
    unique case (state_q)
      ST_IDLE: begin
        if (tick_acc) begin
          state_d = ST_SCAN;
          ptr_d   = '0;
        end
      end
      ST_SCAN: begin
        // Issue one read per cycle; leave once the last read data was seen.
        if (issue) begin
          ptr_d    = ptr_q + NW'(1);
          rd_vld_d = 1'b1;
        end else begin
          state_d = ST_CALC;
        end
      end
      ST_CALC: begin
        ta_d    = ft_w - W'(best.arrival);
        state_d = ST_UPDATE;
      end
      ST_UPDATE: begin
        state_d     = ST_IDLE;
        ran_valid_d = found;
        ran_slot_d  = found ? best_slot_ext[SLOT_W-1:0] : '0;
        finished_d  = fin;
        if (fin) begin
          finish_tick_d = ft_w[OUT_W-1:0];
          turnaround_d  = ta_q[OUT_W-1:0];
          wait_ticks_d  = wt_w[OUT_W-1:0];
        end
        done_cnt_d = done_next;
        all_done_d = (NW'(done_next) >= n_act);
        // Advance time, holding at the top.
        tick_d     = tick_inc_q;
        tick_inc_d = (tick_inc_q == TICK_MAX) ? TICK_MAX
                                              : (tick_inc_q + TICK_WIDTH'(1));
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_IDLE;
      ptr_q          <= '0;
      rd_vld_q       <= 1'b0;
      tick_q         <= '0;
      tick_inc_q     <= TICK_WIDTH'(1);
      done_cnt_q     <= '0;
      cfg_q          <= ENTRIES_RST;
      result_valid_q <= 1'b0;
    end else begin
      state_q        <= state_d;
      ptr_q          <= ptr_d;
      rd_vld_q       <= rd_vld_d;
      tick_q         <= tick_d;
      tick_inc_q     <= tick_inc_d;
      done_cnt_q     <= done_cnt_d;
      result_valid_q <= load_acc || (state_q == ST_UPDATE);
      if (cfg_we_i) begin
        cfg_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rd_slot_q     <= ptr_q[IW-1:0];
    ta_q          <= ta_d;
    ran_valid_q   <= ran_valid_d;
    ran_slot_q    <= ran_slot_d;
    finished_q    <= finished_d;
    finish_tick_q <= finish_tick_d;
    turnaround_q  <= turnaround_d;
    wait_ticks_q  <= wait_ticks_d;
    all_done_q    <= all_done_d;
  end

  assign result_valid_o = result_valid_q;
  assign ran_valid_o    = ran_valid_q;
  assign ran_slot_o     = ran_slot_q;
  assign finished_o     = finished_q;
  assign finish_tick_o  = finish_tick_q;
  assign turnaround_o   = turnaround_q;
  assign wait_ticks_o   = wait_ticks_q;
  assign all_done_o     = all_done_q;

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  `PPSC_ASSERT_NEXT(a_update_beat, state_q == ST_UPDATE, result_valid_o, "tick gave no beat")
  `PPSC_ASSERT_SAME(a_no_write_in_scan, state_q == ST_SCAN, !mem_we, "table write during scan")
  `PPSC_ASSERT_SAME(a_done_only_on_update, done_cnt_q != $past(done_cnt_q), $past(state_q == ST_UPDATE), "done count moved outside update")

endmodule

// ===== verif/preemptive_priority_scheduler_core_test.sv =====
// Self-checking bench for preemptive_priority_scheduler_core: task loads and ticks,
// predicted beat by beat against a behavioral schedule model kept in a small class.
// Depends on ppsc_pkg and the core RTL only.
`timescale 1ns / 1ps

module preemptive_priority_scheduler_core_test;
  import ppsc_pkg::*;

  localparam int NUM_SLOTS = 16;
  localparam int unsigned TICK_MAX = (1 << 20) - 1;
  localparam int PHASE_ITEMS = 201;

  // One result beat as it leaves the core.
  typedef struct packed {
    logic              ran_valid;
    logic [SLOT_W-1:0] ran_slot;
    logic              finished;
    logic [OUT_W-1:0]  finish_tick;
    logic [OUT_W-1:0]  turnaround;
    logic [OUT_W-1:0]  wait_ticks;
    logic              all_done;
  } sched_outcome_t;

  // Schedule model: its own copy of the task table, the time counter and
  // the completion counter, plus the beats still owed by the core.
  class schedule_board;
    logic [ARR_W-1:0]   arr_tab[NUM_SLOTS];
    logic [BURST_W-1:0] burst_tab[NUM_SLOTS];
    logic [BURST_W-1:0] rem_tab[NUM_SLOTS];
    logic [PRIO_W-1:0]  prio_tab[NUM_SLOTS];
    int unsigned        cur_tick;
    int unsigned        done_cnt;
    int unsigned        entries;
    sched_outcome_t     owed_beats[$];
    int unsigned        errors;

    function new();
      for (int i = 0; i < NUM_SLOTS; i++) begin
        arr_tab[i] = '0;
        burst_tab[i] = '0;
        rem_tab[i] = '0;
        prio_tab[i] = '0;
      end
      cur_tick = 0;
      done_cnt = 0;
      entries = ENTRIES_RST;
      errors = 0;
    endfunction

    function int unsigned slots_active();
      return (entries > NUM_SLOTS) ? NUM_SLOTS : entries;
    endfunction

    // Work out the beat for one accepted item and queue it.
    function void note_item(logic op, logic [SLOT_W-1:0] slot, logic [ARR_W-1:0] arr,
                            logic [BURST_W-1:0] burst, logic [PRIO_W-1:0] prio);
      sched_outcome_t o;
      int unsigned n, best, ft, ta, wt;
      bit found;
      o = '0;
      found = 0;
      best = 0;
      if (op == OP_LOAD) begin
        arr_tab[slot] = arr;
        burst_tab[slot] = burst;
        rem_tab[slot] = burst;
        prio_tab[slot] = prio;
      end else begin
        n = slots_active();
        // Smallest priority number wins, then earlier arrival, then lower slot.
        for (int i = 0; i < n; i++) begin
          if (arr_tab[i] <= cur_tick && rem_tab[i] != 0) begin
            if (!found || prio_tab[i] < prio_tab[best] ||
                (prio_tab[i] == prio_tab[best] && arr_tab[i] < arr_tab[best])) begin
              best = i;
              found = 1;
            end
          end
        end
        if (found) begin
          o.ran_valid = 1'b1;
          o.ran_slot = best[SLOT_W-1:0];
          rem_tab[best] = rem_tab[best] - 1'b1;
          if (rem_tab[best] == 0) begin
            ft = (cur_tick < TICK_MAX) ? cur_tick + 1 : TICK_MAX;
            ta = ft - arr_tab[best];
            wt = (ta >= burst_tab[best]) ? ta - burst_tab[best] : 0;
            o.finished = 1'b1;
            o.finish_tick = ft[OUT_W-1:0];
            o.turnaround = ta[OUT_W-1:0];
            o.wait_ticks = wt[OUT_W-1:0];
            if (done_cnt < DONE_MAX) done_cnt++;
          end
        end
        if (cur_tick < TICK_MAX) cur_tick++;
      end
      o.all_done = (done_cnt >= slots_active());
      owed_beats.push_back(o);
    endfunction

    // Compare one beat from the core with the oldest owed beat.
    function void check_outcome(sched_outcome_t got);
      sched_outcome_t exp;
      if (owed_beats.size() == 0) begin
        $error("result beat with nothing expected: %p", got);
        errors++;
        return;
      end
      exp = owed_beats.pop_front();
      if (got.ran_valid !== exp.ran_valid) begin
        $error("ran_valid: expected %0d, got %0d", exp.ran_valid, got.ran_valid);
        errors++;
      end
      if (got.ran_slot !== exp.ran_slot) begin
        $error("ran_slot: expected %0d, got %0d", exp.ran_slot, got.ran_slot);
        errors++;
      end
      if (got.finished !== exp.finished) begin
        $error("finished: expected %0d, got %0d", exp.finished, got.finished);
        errors++;
      end
      if (got.finish_tick !== exp.finish_tick) begin
        $error("finish_tick: expected %0d, got %0d", exp.finish_tick, got.finish_tick);
        errors++;
      end
      if (got.turnaround !== exp.turnaround) begin
        $error("turnaround: expected %0d, got %0d", exp.turnaround, got.turnaround);
        errors++;
      end
      if (got.wait_ticks !== exp.wait_ticks) begin
        $error("wait_ticks: expected %0d, got %0d", exp.wait_ticks, got.wait_ticks);
        errors++;
      end
      if (got.all_done !== exp.all_done) begin
        $error("all_done: expected %0d, got %0d", exp.all_done, got.all_done);
        errors++;
      end
    endfunction
  endclass

  logic                clk_i;
  logic                rst_ni;
  logic                start;
  logic                busy;
  logic                op_i;
  logic [SLOT_W-1:0]   slot_i;
  logic [ARR_W-1:0]    arrival_i;
  logic [BURST_W-1:0]  burst_i;
  logic [PRIO_W-1:0]   prio_level_i;
  logic                cfg_we_i;
  logic [CFG_W-1:0]    cfg_wdata_i;
  logic                result_valid_o;
  logic                ran_valid_o;
  logic [SLOT_W-1:0]   ran_slot_o;
  logic                finished_o;
  logic [OUT_W-1:0]    finish_tick_o;
  logic [OUT_W-1:0]    turnaround_o;
  logic [OUT_W-1:0]    wait_ticks_o;
  logic                all_done_o;

  schedule_board board = new();

  preemptive_priority_scheduler_core i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .op_i           (op_i),
    .slot_i         (slot_i),
    .arrival_i      (arrival_i),
    .burst_i        (burst_i),
    .prio_level_i   (prio_level_i),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .result_valid_o (result_valid_o),
    .ran_valid_o    (ran_valid_o),
    .ran_slot_o     (ran_slot_o),
    .finished_o     (finished_o),
    .finish_tick_o  (finish_tick_o),
    .turnaround_o   (turnaround_o),
    .wait_ticks_o   (wait_ticks_o),
    .all_done_o     (all_done_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Hard stop in case the core hangs with beats still owed.
  initial begin
    #10ms;
    $display("simulation failed");
    $finish;
  end

  // Result beats last one cycle and cannot be held off: sample every edge.
  // Values read here are the ones from before the edge.
  always @(posedge clk_i) begin
    if (rst_ni && result_valid_o === 1'b1) begin
      board.check_outcome({ran_valid_o, ran_slot_o, finished_o, finish_tick_o,
                           turnaround_o, wait_ticks_o, all_done_o});
    end
  end

  // Present one item and hold it until an edge sees start high with busy
  // low; then hand it to the model. Leaves start high for back-to-back beats.
  task automatic issue(input logic op, input logic [SLOT_W-1:0] slot,
                       input logic [ARR_W-1:0] arr, input logic [BURST_W-1:0] burst,
                       input logic [PRIO_W-1:0] prio);
    op_i <= op;
    slot_i <= slot;
    arrival_i <= arr;
    burst_i <= burst;
    prio_level_i <= prio;
    start <= 1'b1;
    @(posedge clk_i);
    while (busy !== 1'b0) @(posedge clk_i);
    board.note_item(op, slot, arr, burst, prio);
  endtask

  // Drop start for a random stretch: mostly none or short, now and then long.
  task automatic idle_gap(input bit quiet);
    int unsigned r, n;
    r = $urandom_range(0, 99);
    n = 0;
    if (!quiet) begin
      if (r >= 95) n = $urandom_range(8, 40);
      else if (r >= 65) n = $urandom_range(1, 3);
    end
    if (n != 0) begin
      start <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
  endtask

  // Random beat: mostly ticks and loads of tasks that arrive soon, with
  // small bursts and crowded priorities so that ties and preemption occur.
  task automatic random_item();
    logic [ARR_W-1:0]   arr;
    logic [BURST_W-1:0] burst;
    logic [PRIO_W-1:0]  prio;
    int unsigned r;
    if ($urandom_range(0, 99) < 55) begin
      issue(OP_TICK, SLOT_W'($urandom), ARR_W'($urandom), BURST_W'($urandom),
            PRIO_W'($urandom));
    end else begin
      r = $urandom_range(0, 99);
      if (r < 70) arr = ARR_W'($urandom_range(0, board.cur_tick + 20));
      else if (r < 90) arr = ARR_W'($urandom_range(0, 3));
      else arr = ARR_W'($urandom);
      r = $urandom_range(0, 99);
      if (r < 75) burst = BURST_W'($urandom_range(1, 6));
      else if (r < 85) burst = '0;
      else if (r < 95) burst = BURST_W'($urandom_range(7, 40));
      else burst = BURST_W'($urandom);
      if ($urandom_range(0, 1)) prio = PRIO_W'($urandom_range(0, 7));
      else prio = PRIO_W'($urandom);
      issue(OP_LOAD, SLOT_W'($urandom), arr, burst, prio);
    end
  endtask

  // Hold until every owed beat is back, then let the core settle.
  task automatic drain();
    start <= 1'b0;
    while (board.owed_beats.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Write entries_in_use while the core is idle.
  task automatic write_entries(input logic [CFG_W-1:0] value);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    board.entries = value;
  endtask

  initial begin
    logic [CFG_W-1:0] phase_cfg[8];
    bit quiet;
    phase_cfg = '{ENTRIES_RST, 5'd1, 5'd31, 5'd0, 5'd2, 5'd16, 5'd9, 5'd16};
    rst_ni <= 1'b0;
    start <= 1'b0;
    op_i <= OP_LOAD;
    slot_i <= '0;
    arrival_i <= '0;
    burst_i <= '0;
    prio_level_i <= '0;
    cfg_we_i <= 1'b0;
    cfg_wdata_i <= '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // Load every slot before the first tick: the table is not cleared at
    // reset, so no slot may be scanned before it holds a task.
    // Slots 0 and 1 tie on priority and arrival: the lower slot goes first.
    issue(OP_LOAD, 4'd0, 16'd2, 16'd1, 8'd5);
    issue(OP_LOAD, 4'd1, 16'd2, 16'd1, 8'd5);
    // Same priority, earlier arrival: slot 2 runs ahead of slots 0 and 1.
    issue(OP_LOAD, 4'd2, 16'd1, 16'd2, 8'd5);
    // Zero burst at the most urgent priority: never runs, never completes.
    issue(OP_LOAD, 4'd3, 16'd1, 16'd0, 8'd0);
    // Arrives at the last tick of the arrival range with the longest burst.
    issue(OP_LOAD, 4'd4, 16'hFFFF, 16'hFFFF, 8'd0);
    // Least urgent priority: only runs when nothing else is ready.
    issue(OP_LOAD, 4'd5, 16'd3, 16'd1, 8'd255);
    for (int i = 6; i < NUM_SLOTS; i++) begin
      issue(OP_LOAD, SLOT_W'(i), ARR_W'(i), BURST_W'((i % 3) + 1), PRIO_W'(i * 16));
      idle_gap(1'b0);
    end
    // First tick is idle (nothing has arrived yet); later ones preempt.
    repeat (8) begin
      issue(OP_TICK, '0, '0, '0, '0);
      idle_gap(1'b0);
    end

    for (int p = 0; p < 8; p++) begin
      if (p != 0) begin
        drain();
        write_entries(phase_cfg[p]);
      end
      // Some phases run with no gaps at all, flat out.
      quiet = (p % 3 == 1);
      for (int k = 0; k < PHASE_ITEMS - ((p == 0) ? 24 : 0); k++) begin
        random_item();
        idle_gap(quiet);
      end
    end
    drain();
    // Random setting, then a short burst of traffic to close out.
    write_entries(CFG_W'($urandom_range(1, 16)));
    repeat (40) begin
      random_item();
      idle_gap(1'b0);
    end
    drain();
    repeat (30) @(posedge clk_i);

    if (board.errors == 0 && board.owed_beats.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+design
design/ppsc_pkg.sv
design/ppsc_task_mem.sv
design/ppsc_pick.sv
design/preemptive_priority_scheduler_core.sv
verif/preemptive_priority_scheduler_core_test.sv
